// ----- rtl/core/asf_pkg.sv -----
// shared constants, register codes and table builders for the symmetry function core
`default_nettype none

package asf_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_FUNC_KIND  = 3'd0;
    localparam logic [2:0] REG_CUTOFF     = 3'd1;
    localparam logic [2:0] REG_ETA        = 3'd2;
    localparam logic [2:0] REG_SHIFT_RS   = 3'd3;
    localparam logic [2:0] REG_ZETA       = 3'd4;
    localparam logic [2:0] REG_LAMBDA_NEG = 3'd5;

    // function kinds
    localparam logic [1:0] KIND_G0 = 2'd0;
    localparam logic [1:0] KIND_G1 = 2'd1;
    localparam logic [1:0] KIND_G4 = 2'd2;
    localparam logic [1:0] KIND_G5 = 2'd3;

    // register reset values
    localparam logic [1:0]  RST_FUNC_KIND  = KIND_G0;
    localparam logic [15:0] RST_CUTOFF     = 16'd24576;
    localparam logic [15:0] RST_ETA        = 16'd4096;
    localparam logic [15:0] RST_SHIFT_RS   = 16'd0;
    localparam logic [4:0]  RST_ZETA       = 5'd1;
    localparam logic        RST_LAMBDA_NEG = 1'b0;

    // latency of every factor unit, from port to factor output
    localparam int CORE_LAT = 17;

    // Q30 constants for the table builders
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned COS_DIVS [0:4] = '{132, 90, 56, 30, 12};
    localparam longint unsigned EXP_DIVS [0:7] = '{8, 7, 6, 5, 4, 3, 2, 1};

    // cutoff value 0.5*(cos(pi*idx/depth)+1) in Q16, depth = 2**cb
    function automatic logic [16:0] cutoff_entry(input longint unsigned idx, input int cb);
        longint unsigned u, th, a, p, t, c;
        u  = (idx << 30) >> cb;
        th = (u * HALF_PI_Q30) >> 30;
        a  = (th * th) >> 30;
        p  = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            p = Q30_ONE - ((a * p) >> 30) / COS_DIVS[i];
        end
        t = ((a * p) >> 30) / 2;
        c = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
        return 17'((c * c + (64'd1 << 43)) >> 44);
    endfunction

    // exp(-x) in Q16 for table index idx, depth = 2**eb covering x in [0,16)
    function automatic logic [16:0] gauss_entry(input longint unsigned idx, input int eb);
        longint unsigned s, p;
        s = (idx << 30) >> (eb + 1);
        p = Q30_ONE;
        for (int k = 0; k < 8; k++) begin
            p = Q30_ONE - ((s * p) >> 30) / EXP_DIVS[k];
        end
        for (int k = 0; k < 5; k++) begin
            p = (p * p) >> 30;
        end
        return 17'((p + (64'd1 << 13)) >> 14);
    endfunction

    // rounded Q16 product of two factors
    function automatic logic [17:0] mul_q16(input logic [17:0] a, input logic [16:0] b);
        logic [35:0] prod;
        prod = 36'(a) * 36'(b) + 36'd32768;
        return prod[33:16];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/asf_cutoff.sv -----
// cutoff factor unit: pipelined index divider and cosine cutoff rom
`default_nettype none

module asf_cutoff #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_dist,
    input  wire logic [15:0] i_cutoff,
    output logic      [16:0] o_fc
);

    // table depth must be a power of two; this module does not check it
    localparam int CB  = $clog2(COS_TABLE_DEPTH);
    localparam int QB  = CB + 1;
    localparam int NW  = CB + 18;
    localparam int PAD = asf_pkg::CORE_LAT - QB - 1;

    typedef logic [16:0] t_fc_rom [0:COS_TABLE_DEPTH];

    function automatic t_fc_rom build_rom();
        t_fc_rom rom;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            rom[i] = asf_pkg::cutoff_entry(64'(i), CB);
        end
        return rom;
    endfunction

    localparam t_fc_rom FC_ROM = build_rom();

    logic [NW-1:0] num;
    logic [NW-1:0] dvs;
    logic [NW-1:0] r_rem [1:QB];
    logic [QB-1:0] r_q   [1:QB];
    logic [QB-1:0] idx;
    logic [16:0]   r_fc;
    logic [16:0]   r_pad [0:PAD-1];

    // index = (r*2*depth + rc) / (2*rc), rounded
    assign num = NW'({i_dist, {QB{1'b0}}}) + NW'(i_cutoff);
    assign dvs = NW'({i_cutoff, 1'b0});

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < QB; s++) begin : g_div
        logic [NW-1:0] rem_src;
        logic [QB-1:0] q_src;
        logic [NW:0]   diff;
        if (s == 0) begin : g_first
            assign rem_src = num;
            assign q_src   = '0;
        end else begin : g_next
            assign rem_src = r_rem[s];
            assign q_src   = r_q[s];
        end
        assign diff = {1'b0, rem_src} - {1'b0, dvs << (QB - 1 - s)};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= diff[NW] ? rem_src : diff[NW-1:0];
                r_q[s+1]   <= {q_src[QB-2:0], ~diff[NW]};
            end
        end
    end

    // clamp index; a zero radius maps to the first entry
    always_comb begin
        if (i_cutoff == '0) begin
            idx = '0;
        end else if (r_q[QB] > QB'(COS_TABLE_DEPTH)) begin
            idx = QB'(COS_TABLE_DEPTH);
        end else begin
            idx = r_q[QB];
        end
    end

    // rom read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fc <= FC_ROM[idx];
        end
    end

    // align to the common factor latency
    for (genvar p = 0; p < PAD; p++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p == 0) begin
                    r_pad[p] <= r_fc;
                end else begin
                    r_pad[p] <= r_pad[p-1];
                end
            end
        end
    end

    assign o_fc = r_pad[PAD-1];

endmodule

`default_nettype wire

// ----- rtl/core/asf_gauss.sv -----
// gaussian factor unit: squared distance sum, eta product and exp rom
`default_nettype none

module asf_gauss #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_dist_ij,
    input  wire logic [15:0] i_dist_ik,
    input  wire logic [15:0] i_dist_jk,
    input  wire logic [15:0] i_shift_rs,
    input  wire logic [15:0] i_eta,
    output logic      [16:0] o_gauss
);

    // table depth must be a power of two; this module does not check it
    localparam int EB  = $clog2(EXP_TABLE_DEPTH);
    localparam int IW  = EB + 11;
    localparam int PAD = asf_pkg::CORE_LAT - 5;

    typedef logic [16:0] t_exp_rom [0:EXP_TABLE_DEPTH-1];

    function automatic t_exp_rom build_rom();
        t_exp_rom rom;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            rom[i] = asf_pkg::gauss_entry(64'(i), EB);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_rom();

    logic [15:0]   d_rad;
    logic [15:0]   d_first;
    logic [31:0]   r_sq1, r_sq2, r_sq3;
    logic [33:0]   r_d2;
    logic [49:0]   r_x;
    logic [50:0]   x_rnd;
    logic [IW-1:0] idx_full;
    logic [EB-1:0] r_eidx;
    logic          r_ezero;
    logic [16:0]   r_g;
    logic [16:0]   r_pad [0:PAD-1];

    // radial distance from the centre
    assign d_rad   = (i_dist_ij >= i_shift_rs) ? i_dist_ij - i_shift_rs : i_shift_rs - i_dist_ij;
    assign d_first = (i_kind == asf_pkg::KIND_G1) ? d_rad : i_dist_ij;

    // squares, then sum, then eta product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq1 <= 32'(d_first) * 32'(d_first);
            r_sq2 <= i_kind[1] ? 32'(i_dist_ik) * 32'(i_dist_ik) : '0;
            r_sq3 <= (i_kind == asf_pkg::KIND_G4) ? 32'(i_dist_jk) * 32'(i_dist_jk) : '0;
            r_d2  <= 34'(r_sq1) + 34'(r_sq2) + 34'(r_sq3);
            r_x   <= 50'(i_eta) * 50'(r_d2);
        end
    end

    // rounded table index over x in [0,16)
    assign x_rnd    = 51'(r_x) + (51'd1 << (39 - EB));
    assign idx_full = x_rnd[50:40-EB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eidx  <= idx_full[EB-1:0];
            r_ezero <= (idx_full[IW-1:EB] != '0);
        end
    end

    // rom read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g <= r_ezero ? 17'd0 : EXP_ROM[r_eidx];
        end
    end

    // align to the common factor latency
    for (genvar p = 0; p < PAD; p++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (p == 0) begin
                    r_pad[p] <= r_g;
                end else begin
                    r_pad[p] <= r_pad[p-1];
                end
            end
        end
    end

    assign o_gauss = r_pad[PAD-1];

endmodule

`default_nettype wire

// ----- rtl/core/asf_angular.sv -----
// angular factor unit: one power step of (1+lambda*cos)/2 per stage
`default_nettype none

module asf_angular (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic signed [15:0] i_cos_theta,
    input  wire logic [4:0]  i_zeta,
    input  wire logic        i_lambda_neg,
    output logic      [17:0] o_ang
);

    localparam int          NSTEP = 16;
    localparam logic [15:0] P_ONE = 16'd32768;

    logic signed [15:0] c_clamp;
    logic signed [16:0] h;
    logic [4:0]         zc;
    logic [15:0]        r_w [0:NSTEP-1];
    logic [15:0]        r_p [1:NSTEP];

    // clamp cosine and zeta
    always_comb begin
        if (i_cos_theta > 16'sd16384) begin
            c_clamp = 16'sd16384;
        end else if (i_cos_theta < -16'sd16384) begin
            c_clamp = -16'sd16384;
        end else begin
            c_clamp = i_cos_theta;
        end
        h = i_lambda_neg ? 17'sd16384 - 17'(c_clamp) : 17'sd16384 + 17'(c_clamp);
        if (i_zeta == '0) begin
            zc = 5'd1;
        end else if (i_zeta > 5'd16) begin
            zc = 5'd16;
        end else begin
            zc = i_zeta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= h[15:0];
        end
    end

    // step i multiplies while i does not exceed zeta
    for (genvar i = 1; i <= NSTEP; i++) begin : g_pow
        logic [15:0] p_src;
        logic [31:0] prod;
        if (i == 1) begin : g_first
            assign p_src = P_ONE;
        end else begin : g_next
            assign p_src = r_p[i-1];
        end
        assign prod = 32'(p_src) * 32'(r_w[i-1]) + 32'd16384;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[i] <= (5'(i) <= zc) ? prod[30:15] : p_src;
            end
        end
        if (i < NSTEP) begin : g_wfwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_w[i] <= r_w[i-1];
                end
            end
        end
    end

    // 2*p in Q16
    assign o_ang = {r_p[NSTEP], 2'b00};

endmodule

`default_nettype wire

// ----- rtl/core/atomic_symmetry_function_core.sv -----
// top level of the atomic symmetry function core
// Computes one Behler-Parrinello symmetry function value (cutoff G0, radial G1, angular G4 or
// G5, chosen by func_kind) per transaction. A new transaction is taken every cycle unless the
// pipeline holds, which it does when a finished result is stalled at the output. Each one passes
// through the factor units (the cutoff index divider retires one quotient bit per stage, the
// angular power takes one multiply per stage for 16 stages), then four stages that chain the
// rounded Q16 products. Tables are built at elaboration; both depths must be powers of two.
// Configuration must be written through the APB-style port while idle; the core does not check.
`default_nettype none

module atomic_symmetry_function_core #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_dist_ij,
    input  wire logic [15:0]        i_dist_ik,
    input  wire logic [15:0]        i_dist_jk,
    input  wire logic signed [15:0] i_cos_theta,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [17:0]        o_sym_value,
    // config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int LAT = asf_pkg::CORE_LAT;

    logic [1:0]  r_func_kind;
    logic [15:0] r_cutoff;
    logic [15:0] r_eta;
    logic [15:0] r_shift_rs;
    logic [4:0]  r_zeta;
    logic        r_lambda_neg;

    logic        adv;
    logic        cfg_wr;
    logic        out_range;
    logic [16:0] fc_ij, fc_ik, fc_jk, gauss;
    logic [17:0] ang;

    logic        r_vld  [0:LAT-1];
    logic [1:0]  r_kind [0:LAT-1];
    logic        r_zero [0:LAT-1];

    logic        r_vld1, r_vld2, r_vld3, r_out_vld;
    logic [1:0]  r_kind1, r_kind2, r_kind3;
    logic        r_zero1, r_zero2, r_zero3;
    logic [17:0] r_v1, r_v2, r_v3, r_out;
    logic [16:0] r_fcij1, r_fcik1, r_fcik2, r_fcjk1, r_fcjk2, r_fcjk3;
    logic [17:0] v1;

    // config write and read
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_kind  <= asf_pkg::RST_FUNC_KIND;
            r_cutoff     <= asf_pkg::RST_CUTOFF;
            r_eta        <= asf_pkg::RST_ETA;
            r_shift_rs   <= asf_pkg::RST_SHIFT_RS;
            r_zeta       <= asf_pkg::RST_ZETA;
            r_lambda_neg <= asf_pkg::RST_LAMBDA_NEG;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                asf_pkg::REG_FUNC_KIND:  r_func_kind  <= pwdata[1:0];
                asf_pkg::REG_CUTOFF:     r_cutoff     <= pwdata[15:0];
                asf_pkg::REG_ETA:        r_eta        <= pwdata[15:0];
                asf_pkg::REG_SHIFT_RS:   r_shift_rs   <= pwdata[15:0];
                asf_pkg::REG_ZETA:       r_zeta       <= pwdata[4:0];
                asf_pkg::REG_LAMBDA_NEG: r_lambda_neg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            asf_pkg::REG_FUNC_KIND:  prdata = 32'(r_func_kind);
            asf_pkg::REG_CUTOFF:     prdata = 32'(r_cutoff);
            asf_pkg::REG_ETA:        prdata = 32'(r_eta);
            asf_pkg::REG_SHIFT_RS:   prdata = 32'(r_shift_rs);
            asf_pkg::REG_ZETA:       prdata = 32'(r_zeta);
            asf_pkg::REG_LAMBDA_NEG: prdata = 32'(r_lambda_neg);
            default:                 prdata = '0;
        endcase
    end

    // whole pipeline advances unless the output holds a stalled transaction
    assign adv     = ~(r_out_vld & i_stall);
    assign o_stall = ~adv;

    // a distance beyond the cutoff zeroes the result: rij alone for G0 and G1, any of the three for G4 and G5
    always_comb begin
        if (r_func_kind[1]) begin
            out_range = (i_dist_ij > r_cutoff) | (i_dist_ik > r_cutoff) | (i_dist_jk > r_cutoff);
        end else begin
            out_range = (i_dist_ij > r_cutoff);
        end
    end

    // factor units
    asf_cutoff #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_cut_ij (
        .i_clk(i_clk), .i_en(adv), .i_dist(i_dist_ij), .i_cutoff(r_cutoff), .o_fc(fc_ij)
    );
    asf_cutoff #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_cut_ik (
        .i_clk(i_clk), .i_en(adv), .i_dist(i_dist_ik), .i_cutoff(r_cutoff), .o_fc(fc_ik)
    );
    asf_cutoff #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_cut_jk (
        .i_clk(i_clk), .i_en(adv), .i_dist(i_dist_jk), .i_cutoff(r_cutoff), .o_fc(fc_jk)
    );

    asf_gauss #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_gauss (
        .i_clk(i_clk), .i_en(adv), .i_kind(r_func_kind),
        .i_dist_ij(i_dist_ij), .i_dist_ik(i_dist_ik), .i_dist_jk(i_dist_jk),
        .i_shift_rs(r_shift_rs), .i_eta(r_eta), .o_gauss(gauss)
    );

    asf_angular u_ang (
        .i_clk(i_clk), .i_en(adv), .i_cos_theta(i_cos_theta),
        .i_zeta(r_zeta), .i_lambda_neg(r_lambda_neg), .o_ang(ang)
    );

    // control travels alongside the factor units
    for (genvar s = 0; s < LAT; s++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (adv) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (s == 0) begin
                    r_kind[s] <= r_func_kind;
                    r_zero[s] <= out_range;
                end else begin
                    r_kind[s] <= r_kind[(s == 0) ? 0 : s-1];
                    r_zero[s] <= r_zero[(s == 0) ? 0 : s-1];
                end
            end
        end
    end

    // first product: gaussian with angular term or with fc(rij); G0 passes fc(rij) alone
    always_comb begin
        case (r_kind[LAT-1])
            asf_pkg::KIND_G0: v1 = 18'(fc_ij);
            asf_pkg::KIND_G1: v1 = asf_pkg::mul_q16(18'(gauss), fc_ij);
            default:          v1 = asf_pkg::mul_q16(ang, gauss);
        endcase
    end

    // valid bits of the product stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld1    <= r_vld[LAT-1];
            r_vld2    <= r_vld1;
            r_vld3    <= r_vld2;
            r_out_vld <= r_vld3;
        end
    end

    // product chain; values stay within 2^17 so the Q2.16 output never saturates
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind1 <= r_kind[LAT-1];
            r_zero1 <= r_zero[LAT-1];
            r_v1    <= v1;
            r_fcij1 <= fc_ij;
            r_fcik1 <= fc_ik;
            r_fcjk1 <= fc_jk;

            r_kind2 <= r_kind1;
            r_zero2 <= r_zero1;
            r_v2    <= r_kind1[1] ? asf_pkg::mul_q16(r_v1, r_fcij1) : r_v1;
            r_fcik2 <= r_fcik1;
            r_fcjk2 <= r_fcjk1;

            r_kind3 <= r_kind2;
            r_zero3 <= r_zero2;
            r_v3    <= r_kind2[1] ? asf_pkg::mul_q16(r_v2, r_fcik2) : r_v2;
            r_fcjk3 <= r_fcjk2;

            if (r_zero3) begin
                r_out <= '0;
            end else if (r_kind3 == asf_pkg::KIND_G4) begin
                r_out <= asf_pkg::mul_q16(r_v3, r_fcjk3);
            end else begin
                r_out <= r_v3;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_sym_value = r_out;

endmodule

`default_nettype wire
